// ----- design/hrfb_pkg.sv -----
// Shared constants, types and a helper function for the hex record to flash block parser.
`default_nettype none

package hrfb_pkg;

  // Bytes in one flash block.
  localparam int unsigned BLOCK_BYTES = 256;
  // Fill counter width: it must be able to reach BLOCK_BYTES itself.
  localparam int unsigned FILL_W = $clog2(BLOCK_BYTES + 1);

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Decoded hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  // Accepts 0-9, a-f and A-F; anything else is flagged not ok.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] diff;
    r.ok  = 1'b0;
    r.nib = 4'd0;
    diff  = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff  = c - 8'h30;
      r.ok  = 1'b1;
      r.nib = diff[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff  = c - 8'h57;
      r.ok  = 1'b1;
      r.nib = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff  = c - 8'h37;
      r.ok  = 1'b1;
      r.nib = diff[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/hex_record_to_flash_block.sv -----
// Intel HEX character parser that numbers data bytes within flash blocks.
//
// Usage: one ASCII character of a hex file is offered per transfer on the
// input channel (text_char_i, end_of_stream_i with in_valid_i/in_ready_o).
// Each character produces at most one result on the output channel
// (out_valid_o/out_ready_i): a data byte with its index in the current
// block, a block close at end of stream, or a format error.
// Latency: the result of a character is presented the cycle after its
// transfer, from a single output register.
// Throughput: one character per cycle while the output is not stalled. The
// parser state updates with each character taken, so the rate is set only by the output register:
// in_ready_o is high while that register is empty or being drained.
// When the receiver stalls with a result pending, in_ready_o drops and
// no character is taken until the result is transferred.
// Reset: the parser waits for a colon with an empty block, and the
// output channel is empty.
`default_nettype none

module hex_record_to_flash_block (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_char_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       byte_index_o,
  output logic [14:0]      block_word_address_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  localparam int unsigned FW = hrfb_pkg::FILL_W;

  phase_e                phase_q, phase_d;
  logic [1:0]            digit_q, digit_d;
  logic [15:0]           field_q, field_d;
  logic [7:0]            rec_len_q, rec_len_d;
  logic [7:0]            count_q, count_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [14:0]           start_q, start_d;
  logic                  drop_q, drop_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            kind_q;
  logic [7:0]            data_q;
  logic [7:0]            index_q;
  logic [14:0]           addr_q;
  logic                  last_q;

  // Result of the character being handled.
  logic                  res_valid;
  hrfb_pkg::kind_e       res_kind;
  logic [7:0]            res_data;
  logic [7:0]            res_index;
  logic                  res_last;

  logic                  in_xfer;
  hrfb_pkg::hex_digit_t  dig;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign dig        = hrfb_pkg::hex_decode(text_char_i);

  // Parser next state and result for one character.
  always_comb begin
    logic [15:0]   field_new;
    logic          field_done;
    logic [7:0]    count_inc;
    logic [FW-1:0] fill_inc;
    logic [FW-1:0] fill_dec;

    phase_d    = phase_q;
    digit_d    = digit_q;
    field_d    = field_q;
    rec_len_d  = rec_len_q;
    count_d    = count_q;
    fill_d     = fill_q;
    start_d    = start_q;
    drop_d     = drop_q;
    res_valid  = 1'b0;
    res_kind   = hrfb_pkg::KIND_DATA;
    res_data   = 8'd0;
    res_index  = 8'd0;
    res_last   = 1'b0;
    field_new  = {field_q[11:0], dig.nib};
    field_done = (phase_q == PH_ADDR) ? (digit_q == 2'd3) : (digit_q != 2'd0);
    count_inc  = count_q + 8'd1;
    fill_inc   = fill_q + FW'(1);
    fill_dec   = '0;

    if (phase_q == PH_WAIT) begin
      if (text_char_i == hrfb_pkg::CHAR_COLON) begin
        phase_d = PH_COUNT;
        digit_d = 2'd0;
        field_d = 16'd0;
        count_d = 8'd0;
        drop_d  = 1'b0;
      end
    end else if (!dig.ok) begin
      // Bad digit: report, abandon the block and resynchronize.
      res_valid = 1'b1;
      res_kind  = hrfb_pkg::KIND_ERROR;
      fill_d    = '0;
      drop_d    = 1'b0;
      phase_d   = PH_WAIT;
      digit_d   = 2'd0;
      field_d   = 16'd0;
      if (text_char_i == hrfb_pkg::CHAR_COLON) begin
        phase_d = PH_COUNT;
        count_d = 8'd0;
      end
    end else if (!field_done) begin
      digit_d = digit_q + 2'd1;
      field_d = field_new;
    end else begin
      digit_d = 2'd0;
      field_d = 16'd0;
      case (phase_q)
        PH_COUNT: begin
          rec_len_d = field_new[7:0];
          phase_d   = PH_ADDR;
        end
        PH_ADDR: begin
          if (fill_q == '0) begin
            start_d = field_new[15:1];
          end
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          count_d = 8'd0;
          phase_d = (rec_len_q != 8'd0) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          if (!drop_q) begin
            res_valid = 1'b1;
            res_kind  = hrfb_pkg::KIND_DATA;
            res_data  = field_new[7:0];
            res_index = 8'(fill_q);
            fill_d    = fill_inc;
            if (fill_inc == FW'(hrfb_pkg::BLOCK_BYTES)) begin
              res_last = 1'b1;
              fill_d   = '0;
              drop_d   = 1'b1;
            end
          end
          count_d = count_inc;
          if (count_inc == rec_len_q) begin
            phase_d = PH_CHECK;
          end
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end

    // End of stream closes the block and returns to waiting for a colon.
    if (end_of_stream_i) begin
      fill_dec = fill_d - FW'(1);
      if (res_valid && res_kind == hrfb_pkg::KIND_DATA) begin
        res_last = 1'b1;
      end else if (!res_valid && fill_d != '0) begin
        res_valid = 1'b1;
        res_kind  = hrfb_pkg::KIND_CLOSE;
        res_index = 8'(fill_dec);
        res_last  = 1'b1;
      end
      phase_d = PH_WAIT;
      digit_d = 2'd0;
      field_d = 16'd0;
      count_d = 8'd0;
      fill_d  = '0;
      drop_d  = 1'b0;
    end
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Parser state and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      digit_q     <= 2'd0;
      field_q     <= 16'd0;
      rec_len_q   <= 8'd0;
      count_q     <= 8'd0;
      fill_q      <= '0;
      start_q     <= 15'd0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= hrfb_pkg::KIND_DATA;
      data_q      <= 8'd0;
      index_q     <= 8'd0;
      addr_q      <= 15'd0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        phase_q   <= phase_d;
        digit_q   <= digit_d;
        field_q   <= field_d;
        rec_len_q <= rec_len_d;
        count_q   <= count_d;
        fill_q    <= fill_d;
        start_q   <= start_d;
        drop_q    <= drop_d;
      end
      // The payload is loaded with each transfer that makes a result.
      if (in_xfer && res_valid) begin
        kind_q  <= res_kind;
        data_q  <= res_data;
        index_q <= res_index;
        addr_q  <= start_d;
        last_q  <= res_last;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign kind_o               = kind_q;
  assign data_byte_o          = data_q;
  assign byte_index_o         = index_q;
  assign block_word_address_o = addr_q;
  assign last_o               = last_q;

  // An error never completes a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == hrfb_pkg::KIND_ERROR) |-> !last_o)
    else $error("error result marked as last");

  // A block close always completes the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == hrfb_pkg::KIND_CLOSE) |-> last_o)
    else $error("block close without last");

  // End of stream leaves the parser idle with an empty block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_stream_i) |=> (phase_q == PH_WAIT && fill_q == '0 && !drop_q))
    else $error("parser not cleared after end of stream");

  // While waiting for a colon no digits are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (digit_q == 2'd0 && field_q == 16'd0))
    else $error("digits pending while waiting for a colon");

endmodule

`default_nettype wire
